/* hdl/scba_pkg.sv */
// ----------------------------------------------------------------------------
// scba_pkg: shared definitions of the size-class buffer allocator
// Field widths, request and status codes, register indexes and the
// decoder result record used by the allocator core and its class decoder.
// ----------------------------------------------------------------------------
package scba_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int SIZE_W      = 24;
    localparam int REQ_W       = 2;
    localparam int CLS_IN_W    = 3;
    localparam int SLOT_IN_W   = 6;
    localparam int STATUS_W    = 3;
    localparam int CNT_OUT_W   = 8;
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 1;

    // Busy map words hold this many slots each.
    localparam int WORD_W    = 64;
    localparam int WORD_BITS = 6;

    // Wide enough for any class number the decoder can return.
    localparam int CLS_DEC_W = 5;

    // Defaults for the top level parameters.
    localparam int DEF_NUM_CLASSES     = 8;
    localparam int DEF_SLOTS_PER_CLASS = 64;
    localparam int DEF_COUNT_BITS      = 8;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DROP  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_TOO_LARGE = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FREE      = 3'd3;
    localparam logic [STATUS_W-1:0] STS_SATURATED = 3'd4;
    localparam logic [STATUS_W-1:0] STS_BAD       = 3'd5;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 1'd1;
    localparam logic [SIZE_W-1:0]    RST_MIN_SIZE = 24'd64;
    localparam logic [SIZE_W-1:0]    RST_MAX_SIZE = 24'd8192;

    // What the class decoder reports about the request being worked on.
    typedef struct packed {
        logic                 too_large;
        logic [CLS_DEC_W-1:0] alloc_cls;
        logic                 handle_ok;
    } t_cls_dec;

endpackage

/* hdl/size_class_buffer_refcount_allocator_core.sv */
// ----------------------------------------------------------------------------
// size_class_buffer_refcount_allocator_core: buffer allocator with counts
// Power-of-two size classes, a busy bitmap per class and a reference count
// per slot, both kept in single-port synchronous memories.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A reference request and an allocation
// that finds a free slot in the first 64-slot busy word pass through decode,
// memory read, then modify and write back before the result is loaded.
// Every further busy word an allocation has to scan adds a read and a test,
// and a request rejected at decode goes on to the result with no memory read.
// After reset the block clears both memories, one count entry per cycle, for
// all 2^(clog2(NUM_CLASSES) + clog2(SLOTS_PER_CLASS)) count entries (512 by
// default) before it takes its first request; configuration writes are taken
// meanwhile. A finished result waits in the output register while the next
// request is already accepted.
module size_class_buffer_refcount_allocator_core #(
    parameter int NUM_CLASSES     = scba_pkg::DEF_NUM_CLASSES,
    parameter int SLOTS_PER_CLASS = scba_pkg::DEF_SLOTS_PER_CLASS,
    parameter int COUNT_BITS      = scba_pkg::DEF_COUNT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [scba_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [scba_pkg::SIZE_W-1:0]      i_cfg_wdata,
    // Request stream.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: request_size[23:0], class_index[26:24], slot_index[32:27], zero pad
    input  logic [scba_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: req_type[1:0], null_handle[2]
    input  logic [scba_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    // Result stream.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: status[2:0], granted_class[5:3], granted_slot[11:6],
    //        count_after[19:12], zero pad
    output logic [scba_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import scba_pkg::*;

    localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SLOT_W     = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
    localparam int WORDS      = (SLOTS_PER_CLASS + WORD_W - 1) / WORD_W;
    localparam int WRD_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CA_W       = CLS_W + SLOT_W;
    localparam int BA_W       = CLS_W + WRD_W;
    localparam int CNT_DEPTH  = 1 << CA_W;
    localparam int BUSY_DEPTH = 1 << BA_W;
    localparam logic [WRD_W-1:0]      LAST_WORD = WRD_W'(WORDS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DEC   = 3'd2;
    localparam logic [2:0] ST_RESP  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_SCAN  = 3'd5;
    localparam logic [2:0] ST_UPD   = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [CA_W-1:0]        r_clr;
    logic [SIZE_W-1:0]      r_min_size, r_max_size;

    logic [REQ_W-1:0]       r_type;
    logic [SIZE_W-1:0]      r_size;
    logic [CLS_IN_W-1:0]    r_hcls;
    logic [SLOT_IN_W-1:0]   r_hslot;
    logic                   r_null;

    t_cls_dec               dec, r_dec;
    logic [WRD_W-1:0]       r_word, n_word;
    logic [OUT_TDATA_W-1:0] r_resp, n_resp;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   out_free;
    logic                   n_load;
    logic [OUT_TDATA_W-1:0] n_load_data;

    // Memories and their ports.
    logic [COUNT_BITS-1:0]  cnt_mem [CNT_DEPTH];
    logic [WORD_W-1:0]      busy_mem [BUSY_DEPTH];
    logic [COUNT_BITS-1:0]  r_cnt_rd;
    logic [WORD_W-1:0]      r_busy_rd;
    logic                   cnt_we, cnt_re, busy_we, busy_re;
    logic [CA_W-1:0]        cnt_wa, cnt_ra;
    logic [BA_W-1:0]        busy_wa, busy_ra;
    logic [COUNT_BITS-1:0]  cnt_wd;
    logic [WORD_W-1:0]      busy_wd;

    // Handle and allocation addresses.
    logic [CLS_W-1:0]       hnd_cls_a, alloc_cls_a, op_cls;
    logic [SLOT_W-1:0]      hnd_slot_a, alloc_slot_a;
    logic [WRD_W-1:0]       hnd_word;
    logic [WORD_BITS-1:0]   hnd_bit;
    logic [WORD_W-1:0]      free_bits;
    logic [WORD_BITS-1:0]   free_bit;
    logic                   any_free;
    logic [COUNT_BITS-1:0]  cnt_inc, cnt_dec;

    function automatic logic [OUT_TDATA_W-1:0] pack_result(
        input logic [STATUS_W-1:0]  status,
        input logic [CLS_IN_W-1:0]  cls,
        input logic [SLOT_IN_W-1:0] slot,
        input logic [CNT_OUT_W-1:0] cnt
    );
        pack_result = OUT_TDATA_W'({cnt, slot, cls, status});
    endfunction

    scba_class_dec #(
        .NUM_CLASSES     (NUM_CLASSES),
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
    ) u_class_dec (
        .i_min_size (r_min_size),
        .i_max_size (r_max_size),
        .i_req_size (r_size),
        .i_hnd_cls  (r_hcls),
        .i_hnd_slot (r_hslot),
        .o_dec      (dec)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign out_free   = !r_out_valid || i_m_tready;

    assign hnd_cls_a   = CLS_W'(r_hcls);
    assign hnd_slot_a  = SLOT_W'(r_hslot);
    assign alloc_cls_a = CLS_W'(r_dec.alloc_cls);
    assign op_cls      = (r_type == REQ_ALLOC) ? alloc_cls_a : hnd_cls_a;
    assign hnd_word    = WRD_W'(hnd_slot_a >> WORD_BITS);
    assign hnd_bit     = WORD_BITS'(hnd_slot_a);
    assign cnt_inc     = r_cnt_rd + COUNT_BITS'(1);
    assign cnt_dec     = r_cnt_rd - COUNT_BITS'(1);

    // Free slots of the current busy word; slots past the class end count as busy.
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            free_bits[b] = !r_busy_rd[b]
                && (32'({r_word, WORD_BITS'(b)}) < SLOTS_PER_CLASS);
        end
        any_free = |free_bits;
        free_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                free_bit = WORD_BITS'(b);
            end
        end
        alloc_slot_a = SLOT_W'({r_word, free_bit});
    end

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_resp      = r_resp;
        n_load      = 1'b0;
        n_load_data = r_resp;
        cnt_we      = 1'b0;
        cnt_wa      = {op_cls, hnd_slot_a};
        cnt_wd      = '0;
        cnt_re      = 1'b0;
        cnt_ra      = {hnd_cls_a, hnd_slot_a};
        busy_we     = 1'b0;
        busy_wa     = {op_cls, r_word};
        busy_wd     = r_busy_rd;
        busy_re     = 1'b0;
        busy_ra     = {op_cls, (r_type == REQ_ALLOC) ? r_word : hnd_word};

        case (r_state)
            ST_CLEAR: begin
                cnt_we  = 1'b1;
                cnt_wa  = r_clr;
                cnt_wd  = '0;
                busy_we = 1'b1;
                busy_wa = BA_W'(r_clr);
                busy_wd = '0;
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                n_word  = '0;
                n_state = ST_RESP;
                case (r_type)
                    REQ_ALLOC: begin
                        if (dec.too_large) begin
                            n_resp = pack_result(STS_TOO_LARGE, '0, '0, '0);
                        end else begin
                            n_state = ST_READ;
                        end
                    end
                    REQ_ADD: begin
                        if (r_null || !dec.handle_ok) begin
                            n_resp = pack_result(STS_BAD, r_hcls, r_hslot, '0);
                        end else begin
                            n_state = ST_READ;
                        end
                    end
                    REQ_DROP: begin
                        if (r_null) begin
                            n_resp = pack_result(STS_OK, '0, '0, '0);
                        end else if (!dec.handle_ok) begin
                            n_resp = pack_result(STS_BAD, r_hcls, r_hslot, '0);
                        end else begin
                            n_state = ST_READ;
                        end
                    end
                    default: begin
                        n_resp = pack_result(STS_BAD, '0, '0, '0);
                    end
                endcase
            end
            ST_RESP: begin
                if (out_free) begin
                    n_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                busy_re = 1'b1;
                cnt_re  = (r_type != REQ_ALLOC);
                n_state = (r_type == REQ_ALLOC) ? ST_SCAN : ST_UPD;
            end
            ST_SCAN: begin
                if (any_free) begin
                    if (out_free) begin
                        cnt_we      = 1'b1;
                        cnt_wa      = {alloc_cls_a, alloc_slot_a};
                        cnt_wd      = COUNT_BITS'(1);
                        busy_we     = 1'b1;
                        busy_wd     = r_busy_rd | (WORD_W'(1) << free_bit);
                        n_load      = 1'b1;
                        n_load_data = pack_result(STS_OK, CLS_IN_W'(r_dec.alloc_cls),
                                                  SLOT_IN_W'(alloc_slot_a), CNT_OUT_W'(1));
                        n_state     = ST_IDLE;
                    end
                end else if (r_word == LAST_WORD) begin
                    if (out_free) begin
                        n_load      = 1'b1;
                        n_load_data = pack_result(STS_FULL, CLS_IN_W'(r_dec.alloc_cls),
                                                  '0, '0);
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_word  = r_word + WRD_W'(1);
                    n_state = ST_READ;
                end
            end
            ST_UPD: begin
                busy_wa = {hnd_cls_a, hnd_word};
                if (out_free) begin
                    n_load  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_type == REQ_ADD) begin
                        if (r_cnt_rd == CNT_MAX) begin
                            n_load_data = pack_result(STS_SATURATED, r_hcls, r_hslot,
                                                      CNT_OUT_W'(r_cnt_rd));
                        end else begin
                            cnt_we      = 1'b1;
                            cnt_wd      = cnt_inc;
                            busy_we     = 1'b1;
                            busy_wd     = r_busy_rd | (WORD_W'(1) << hnd_bit);
                            n_load_data = pack_result(STS_OK, r_hcls, r_hslot,
                                                      CNT_OUT_W'(cnt_inc));
                        end
                    end else begin
                        if (r_cnt_rd == '0) begin
                            n_load_data = pack_result(STS_FREE, r_hcls, r_hslot, '0);
                        end else begin
                            cnt_we      = 1'b1;
                            cnt_wd      = cnt_dec;
                            // The slot goes free when its last reference is dropped.
                            busy_we     = (cnt_dec == '0);
                            busy_wd     = r_busy_rd & ~(WORD_W'(1) << hnd_bit);
                            n_load_data = pack_result(STS_OK, r_hcls, r_hslot,
                                                      CNT_OUT_W'(cnt_dec));
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_min_size  <= RST_MIN_SIZE;
            r_max_size  <= RST_MAX_SIZE;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + CA_W'(1);
            end
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_SIZE: r_min_size <= i_cfg_wdata;
                    CFG_MAX_SIZE: r_max_size <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_s_tvalid) begin
            r_type  <= i_s_tuser[1:0];
            r_null  <= i_s_tuser[2];
            r_size  <= i_s_tdata[23:0];
            r_hcls  <= i_s_tdata[26:24];
            r_hslot <= i_s_tdata[32:27];
        end
        if (r_state == ST_DEC) begin
            r_dec <= dec;
        end
        r_word <= n_word;
        r_resp <= n_resp;
        if (n_load) begin
            r_out_data <= n_load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re) begin
            r_cnt_rd <= cnt_mem[cnt_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (busy_we) begin
            busy_mem[busy_wa] <= busy_wd;
        end
        if (busy_re) begin
            r_busy_rd <= busy_mem[busy_ra];
        end
    end

endmodule

/* hdl/scba_class_dec.sv */
// ----------------------------------------------------------------------------
// scba_class_dec: size class decoder
// Picks the smallest power-of-two class that covers an allocation size and
// judges whether a handle names an existing class and slot.
// ----------------------------------------------------------------------------
module scba_class_dec #(
    parameter int NUM_CLASSES     = scba_pkg::DEF_NUM_CLASSES,
    parameter int SLOTS_PER_CLASS = scba_pkg::DEF_SLOTS_PER_CLASS
) (
    input  logic [scba_pkg::SIZE_W-1:0]    i_min_size,
    input  logic [scba_pkg::SIZE_W-1:0]    i_max_size,
    input  logic [scba_pkg::SIZE_W-1:0]    i_req_size,
    input  logic [scba_pkg::CLS_IN_W-1:0]  i_hnd_cls,
    input  logic [scba_pkg::SLOT_IN_W-1:0] i_hnd_slot,
    output scba_pkg::t_cls_dec             o_dec
);
    import scba_pkg::*;

    localparam int CAP_W = SIZE_W + NUM_CLASSES;

    always_comb begin
        logic [SIZE_W-1:0]      eff_min;
        logic [CAP_W-1:0]       cap;
        logic [NUM_CLASSES-1:0] ge;
        logic [NUM_CLASSES-1:0] le;
        logic                   found;
        logic                   fits;
        logic                   exists;

        // A zero minimum behaves as one byte.
        eff_min = (i_min_size == '0) ? SIZE_W'(1) : i_min_size;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            cap   = CAP_W'(eff_min) << c;
            ge[c] = (cap >= CAP_W'(i_req_size));
            le[c] = (cap <= CAP_W'(i_max_size));
        end

        // Capacities grow with the class, so the lowest covering class wins.
        found           = 1'b0;
        fits            = 1'b0;
        o_dec.alloc_cls = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (ge[c]) begin
                found           = 1'b1;
                fits            = le[c];
                o_dec.alloc_cls = CLS_DEC_W'(c);
            end
        end
        o_dec.too_large = !(found && fits);

        exists = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (32'(i_hnd_cls) == c) begin
                exists = le[c];
            end
        end
        o_dec.handle_ok = exists && (32'(i_hnd_slot) < SLOTS_PER_CLASS);
    end

endmodule
